### hdl/brct_pkg.sv
// ----------------------------------------------------------------------------
// brct_pkg
// types, codes and helpers shared by the reservation table block
// ----------------------------------------------------------------------------
package brct_pkg;

    localparam int TABLE_ENTRIES_DEF = 65536;
    localparam int BATCH_SLOTS_DEF   = 1024;

    localparam int TID_W  = 32;
    localparam int SLOT_W = 10;
    localparam int DATA_W = 64;

    typedef enum logic [2:0] {
        MODE_RSV_WR,
        MODE_RSV_RD,
        MODE_CHK_WAW,
        MODE_CHK_RAW,
        MODE_CHK_WAR,
        MODE_SET_ABORT,
        MODE_WR_VAL,
        MODE_RD_VAL
    } brct_mode_t;

    localparam logic [2:0] RES_NONE      = 3'd0;
    localparam logic [2:0] RES_LOST      = 3'd1;
    localparam logic [2:0] RES_HELD      = 3'd2;
    localparam logic [2:0] RES_WON       = 3'd3;
    localparam logic [2:0] RES_UNCHANGED = 3'd4;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_ABORT,
        ST_DONE
    } brct_state_t;

    // input word, key in the lowest bits
    typedef struct packed {
        logic [DATA_W-1:0] write_data;
        logic              abort_mark;
        logic [SLOT_W-1:0] tx_slot;
        logic [TID_W-1:0]  batch;
        logic [TID_W-1:0]  tid;
        logic [15:0]       key;
    } item_t;

    // result word, conflict in the lowest bit
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [2:0]        reserve_result;
        logic              conflict;
    } result_t;

    // one table row
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [TID_W-1:0]  rd_tid;
        logic [TID_W-1:0]  rd_batch;
        logic [SLOT_W-1:0] wr_slot;
        logic [TID_W-1:0]  wr_tid;
        logic [TID_W-1:0]  wr_batch;
    } row_t;

    typedef struct packed {
        logic [2:0]       code;
        logic             won;
        logic [TID_W-1:0] tid;
        logic [TID_W-1:0] batch;
    } rsv_t;

    localparam int IN_W        = $bits(item_t);
    localparam int IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
    localparam int OUT_W       = $bits(result_t);
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int ROW_W       = $bits(row_t);

    function automatic rsv_t rsv_rule(input logic [TID_W-1:0] held_tid,
                                      input logic [TID_W-1:0] held_batch,
                                      input logic [TID_W-1:0] req_tid,
                                      input logic [TID_W-1:0] req_batch);
        rsv_t r;
        r.code  = RES_UNCHANGED;
        r.won   = 1'b0;
        r.tid   = held_tid;
        r.batch = held_batch;
        if (held_tid < req_tid && held_batch == req_batch) begin
            r.code = RES_LOST;
        end else if (held_tid == req_tid && held_batch == req_batch) begin
            r.code = RES_HELD;
        end else if (held_tid > req_tid || held_batch < req_batch || held_tid == '0) begin
            r.code = RES_WON;
            r.won  = 1'b1;
            r.tid  = req_tid;
            if (held_batch < req_batch) begin
                r.batch = req_batch;
            end
        end
        return r;
    endfunction

endpackage

### hdl/brct_ram.sv
// ----------------------------------------------------------------------------
// brct_ram
// single write port, single read port memory with registered read data
// ----------------------------------------------------------------------------
module brct_ram
#(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_array[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/brct_ctrl.sv
// ----------------------------------------------------------------------------
// brct_ctrl
// access sequencer: clearing pass, table read-modify-write, abort map write and lookup
// ----------------------------------------------------------------------------
module brct_ctrl
    import brct_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int BATCH_SLOTS   = BATCH_SLOTS_DEF,
    localparam int TAW = $clog2(TABLE_ENTRIES),
    localparam int SAW = (BATCH_SLOTS > 1) ? $clog2(BATCH_SLOTS) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // key, tid, batch, tx_slot, abort_mark, write_data
    input  logic [2:0]             s_tuser,   // mode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // conflict, reserve_result, read_data
    output logic                   tbl_we,
    output logic [TAW-1:0]         tbl_waddr,
    output row_t                   tbl_wdata,
    output logic                   tbl_re,
    output logic [TAW-1:0]         tbl_raddr,
    input  row_t                   tbl_rdata,
    output logic                   ab_we,
    output logic [SAW-1:0]         ab_waddr,
    output logic                   ab_wdata,
    output logic                   ab_re,
    output logic [SAW-1:0]         ab_raddr,
    input  logic                   ab_rdata
);

    localparam int CLR_N = (TABLE_ENTRIES > BATCH_SLOTS) ? TABLE_ENTRIES : BATCH_SLOTS;
    localparam int CW    = $clog2(CLR_N);

    brct_state_t      state_reg, state_next;
    logic [CW-1:0]    clr_cnt_reg, clr_cnt_next;
    item_t            item_reg;
    brct_mode_t       mode_reg;
    result_t          res_reg;
    result_t          m_data_reg;
    logic             m_tvalid_reg;

    item_t            in_item;
    logic             accept;
    logic             out_free;
    logic [31:0]      in_key_ext;
    logic [31:0]      key_ext;
    logic [31:0]      slot_ext;
    logic [31:0]      ws_ext;
    logic [31:0]      clr_ext;
    logic             key_ok;
    logic             slot_ok;
    logic             ws_ok;
    rsv_t             rsv_wr;
    rsv_t             rsv_rd;
    row_t             row_new;
    logic             look_we;
    logic             need_abort;
    result_t          look_res;

    assign in_item    = item_t'(s_tdata[IN_W-1:0]);
    assign accept     = s_tvalid && s_tready;
    assign out_free   = !m_tvalid_reg || m_tready;
    assign in_key_ext = 32'(in_item.key);
    assign key_ext    = 32'(item_reg.key);
    assign slot_ext   = 32'(item_reg.tx_slot);
    assign ws_ext     = 32'(tbl_rdata.wr_slot);
    assign clr_ext    = 32'(clr_cnt_reg);
    assign key_ok     = key_ext < 32'(TABLE_ENTRIES);
    assign slot_ok    = slot_ext < 32'(BATCH_SLOTS);
    assign ws_ok      = ws_ext < 32'(BATCH_SLOTS);

    assign rsv_wr = rsv_rule(tbl_rdata.wr_tid, tbl_rdata.wr_batch, item_reg.tid, item_reg.batch);
    assign rsv_rd = rsv_rule(tbl_rdata.rd_tid, tbl_rdata.rd_batch, item_reg.tid, item_reg.batch);

    // row update and result of the lookup cycle
    always_comb
    begin
        row_new    = tbl_rdata;
        look_we    = 1'b0;
        need_abort = 1'b0;
        look_res   = '0;
        case (mode_reg)
            MODE_RSV_WR:
            begin
                look_res.reserve_result = key_ok ? rsv_wr.code : RES_UNCHANGED;
                row_new.wr_tid   = rsv_wr.tid;
                row_new.wr_batch = rsv_wr.batch;
                row_new.wr_slot  = item_reg.tx_slot;
                look_we          = key_ok && rsv_wr.won;
            end
            MODE_RSV_RD:
            begin
                look_res.reserve_result = key_ok ? rsv_rd.code : RES_UNCHANGED;
                row_new.rd_tid   = rsv_rd.tid;
                row_new.rd_batch = rsv_rd.batch;
                look_we          = key_ok && rsv_rd.won;
            end
            MODE_CHK_WAW:
            begin
                look_res.conflict = key_ok && (tbl_rdata.wr_tid != item_reg.tid ||
                                               tbl_rdata.wr_batch != item_reg.batch);
            end
            MODE_CHK_RAW:
            begin
                if (key_ok && item_reg.tid > tbl_rdata.wr_tid &&
                    tbl_rdata.wr_batch == item_reg.batch && tbl_rdata.wr_tid != '0)
                begin
                    // writer slot off the map counts as not aborted
                    look_res.conflict = 1'b1;
                    need_abort        = ws_ok;
                end
            end
            MODE_CHK_WAR:
            begin
                look_res.conflict = key_ok && item_reg.tid > tbl_rdata.rd_tid &&
                                    tbl_rdata.rd_batch == item_reg.batch &&
                                    tbl_rdata.rd_tid != '0;
            end
            MODE_WR_VAL:
            begin
                row_new.value = item_reg.write_data;
                look_we       = key_ok;
            end
            MODE_RD_VAL:
            begin
                look_res.read_data = key_ok ? tbl_rdata.value : '0;
            end
            default:
            begin
                look_res = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + CW'(1);
                if (clr_cnt_reg == CW'(CLR_N - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = need_abort ? ST_ABORT : ST_DONE;
            end
            ST_ABORT:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory controls
    always_comb
    begin
        s_tready  = 1'b0;
        tbl_we    = 1'b0;
        tbl_waddr = key_ext[TAW-1:0];
        tbl_wdata = row_new;
        tbl_re    = 1'b0;
        tbl_raddr = in_key_ext[TAW-1:0];
        ab_we     = 1'b0;
        ab_waddr  = slot_ext[SAW-1:0];
        ab_wdata  = item_reg.abort_mark;
        ab_re     = 1'b0;
        ab_raddr  = ws_ext[SAW-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                tbl_we    = clr_ext < 32'(TABLE_ENTRIES);
                tbl_waddr = clr_ext[TAW-1:0];
                tbl_wdata = '0;
                ab_we     = clr_ext < 32'(BATCH_SLOTS);
                ab_waddr  = clr_ext[SAW-1:0];
                ab_wdata  = 1'b0;
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                tbl_re   = s_tvalid;
            end
            ST_LOOK:
            begin
                tbl_we = look_we;
                ab_we  = (mode_reg == MODE_SET_ABORT) && slot_ok;
                ab_re  = need_abort;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (state_reg == ST_DONE && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_item;
            mode_reg <= brct_mode_t'(s_tuser);
        end
        if (state_reg == ST_LOOK)
        begin
            res_reg <= look_res;
        end
        if (state_reg == ST_ABORT)
        begin
            res_reg.conflict <= !ab_rdata;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            m_data_reg <= res_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_TDATA_W'(m_data_reg);

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CLEAR |-> !s_tready)
        else $error("item accepted during clearing pass");

    a_accept_to_look: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_LOOK)
        else $error("accepted item not looked up");

    a_abort_only_raw: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_ABORT |-> mode_reg == MODE_CHK_RAW && $past(ab_re))
        else $error("abort lookup outside raw check");

    a_done_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DONE && out_free |=> m_tvalid && state_reg == ST_IDLE)
        else $error("result not delivered");

    a_no_write_outside: assert property (@(posedge clk) disable iff (!rst_n)
        tbl_we |-> state_reg == ST_CLEAR || state_reg == ST_LOOK)
        else $error("table written outside clear or lookup");

endmodule

### hdl/batch_reservation_conflict_table_unit.sv
// ----------------------------------------------------------------------------
// batch_reservation_conflict_table_unit
// per-record reservation and conflict table for batched transactions
// ----------------------------------------------------------------------------
// sequence: an accepted word reads its table row, the lookup state registers
// the result and writes the row back, a raw check with a writer slot on the map
// then reads the abort map, and the done state hands out the result word;
// one word at a time, the next is taken only after the result word is handed out
// reset: clearing pass zeroes every table row and abort map slot, no input taken
module batch_reservation_conflict_table_unit
    import brct_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF,
    parameter int BATCH_SLOTS   = BATCH_SLOTS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // key, tid, batch, tx_slot, abort_mark, write_data
    input  logic [2:0]             s_tuser,   // mode
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata    // conflict, reserve_result, read_data
);

    localparam int TAW = $clog2(TABLE_ENTRIES);
    localparam int SAW = (BATCH_SLOTS > 1) ? $clog2(BATCH_SLOTS) : 1;

    logic           tbl_we;
    logic [TAW-1:0] tbl_waddr;
    row_t           tbl_wdata;
    logic           tbl_re;
    logic [TAW-1:0] tbl_raddr;
    row_t           tbl_rdata;
    logic           ab_we;
    logic [SAW-1:0] ab_waddr;
    logic           ab_wdata;
    logic           ab_re;
    logic [SAW-1:0] ab_raddr;
    logic           ab_rdata;

    brct_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .BATCH_SLOTS   (BATCH_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .tbl_we    (tbl_we),
        .tbl_waddr (tbl_waddr),
        .tbl_wdata (tbl_wdata),
        .tbl_re    (tbl_re),
        .tbl_raddr (tbl_raddr),
        .tbl_rdata (tbl_rdata),
        .ab_we     (ab_we),
        .ab_waddr  (ab_waddr),
        .ab_wdata  (ab_wdata),
        .ab_re     (ab_re),
        .ab_raddr  (ab_raddr),
        .ab_rdata  (ab_rdata)
    );

    brct_ram #(
        .DEPTH (TABLE_ENTRIES),
        .WIDTH (ROW_W)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (tbl_re),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    brct_ram #(
        .DEPTH (BATCH_SLOTS),
        .WIDTH (1)
    ) u_abort (
        .clk   (clk),
        .we    (ab_we),
        .waddr (ab_waddr),
        .wdata (ab_wdata),
        .re    (ab_re),
        .raddr (ab_raddr),
        .rdata (ab_rdata)
    );

endmodule
